FILE: hdl/prfm_pkg.sv
package prfm_pkg;

  localparam int NUM_REGS    = 32;
  localparam int INSTR_BYTES = 4;
  localparam int REG_W       = $clog2(NUM_REGS);
  localparam int SKIP_W      = 25;

  localparam logic [31:0] BLR_WORD     = 32'h4e80_0020;
  localparam logic [31:0] KEEP_OP_AALK = 32'hfc00_0003;
  localparam logic [31:0] KEEP_HIGH    = 32'hffff_0000;
  localparam logic [31:0] KEEP_NO_A    = 32'hffe0_ffff;
  localparam logic [31:0] LI_FIELD     = 32'h03ff_fffc;
  localparam logic [31:0] BD_FIELD     = 32'h0000_fffc;
  localparam logic [31:0] LI_SIGN      = 32'h0200_0000;
  localparam logic [31:0] BD_SIGN      = 32'h0000_8000;

  // primary opcodes
  localparam logic [5:0] OP_ADDIC    = 6'd12;
  localparam logic [5:0] OP_ADDIC_RC = 6'd13;
  localparam logic [5:0] OP_ADDI     = 6'd14;
  localparam logic [5:0] OP_ADDIS    = 6'd15;
  localparam logic [5:0] OP_BC       = 6'd16;
  localparam logic [5:0] OP_B        = 6'd18;
  localparam logic [5:0] OP_ORI      = 6'd24;
  localparam logic [5:0] OP_MEM_LO   = 6'd32;
  localparam logic [5:0] OP_STMW     = 6'd47;
  localparam logic [5:0] OP_MEM_HI   = 6'd55;

  // small-data base registers
  localparam logic [REG_W-1:0] REG_ZERO = REG_W'(0);
  localparam logic [REG_W-1:0] REG_SDA2 = REG_W'(2);
  localparam logic [REG_W-1:0] REG_SDA  = REG_W'(13);

  typedef struct packed {
    logic [31:0]       word;     // statically masked word
    logic [REG_W-1:0]  reg_a;
    logic [REG_W-1:0]  reg_d;
    logic [SKIP_W-1:0] disp;     // forward branch distance, zero if none
    logic              lis;
    logic              blr;
    logic              use_acc;  // load/store or addi family
    logic              update;
    logic              last;
  } prfm_item_t;

endpackage

FILE: hdl/prfm_front.sv
module prfm_front
  import prfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  input  logic        last_of_section,
  input  logic        push_ready,
  output logic        push_valid,
  output prfm_item_t  push_item
);

  logic       item_valid;
  prfm_item_t item;
  prfm_item_t dec;
  logic [5:0] op;
  logic       plain;
  logic       is_mem;
  logic       is_addi;
  logic       is_lis;
  logic [31:0] mask;
  logic       load;

  always_comb begin
    op      = instr_word[31:26];
    plain   = (instr_word[1:0] == 2'b00);
    is_mem  = op inside {[OP_MEM_LO:OP_MEM_HI]};
    is_addi = op inside {OP_ADDIC, OP_ADDIC_RC, OP_ADDI, OP_ORI};
    is_lis  = (op == OP_ADDIS) && (instr_word[20:16] == REG_ZERO);

    dec.disp = '0;
    if (op == OP_B && plain && (instr_word & LI_SIGN) == '0) begin
      dec.disp = instr_word[SKIP_W-1:0] & LI_FIELD[SKIP_W-1:0];
    end else if (op == OP_BC && plain && (instr_word & BD_SIGN) == '0) begin
      dec.disp = SKIP_W'(instr_word[15:0] & BD_FIELD[15:0]);
    end

    mask = '1;
    if (op == OP_B) begin
      mask = KEEP_OP_AALK;
    end else if ((is_mem && (instr_word[20:16] == REG_ZERO || instr_word[20:16] == REG_SDA2 ||
                             instr_word[20:16] == REG_SDA)) ||
                 (is_addi && (instr_word[20:16] == REG_SDA2 ||
                              instr_word[20:16] == REG_SDA))) begin
      mask = KEEP_HIGH & KEEP_NO_A;
    end else if (is_lis) begin
      mask = KEEP_HIGH;
    end

    dec.word    = instr_word & mask;
    dec.reg_a   = instr_word[20:16];
    dec.reg_d   = instr_word[25:21];
    dec.lis     = is_lis;
    dec.blr     = (instr_word == BLR_WORD);
    dec.use_acc = is_mem || is_addi;
    dec.update  = is_mem && op[0] && (op != OP_STMW);
    dec.last    = last_of_section;
  end

  assign push_valid = item_valid;
  assign push_item  = item;
  assign in_stall   = item_valid && !push_ready;
  assign load       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (push_ready) begin
      item_valid <= 1'b0;
    end
    if (load) begin
      item <= dec;
    end
  end

endmodule

FILE: hdl/prfm_queue.sv
module prfm_queue
  import prfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  prfm_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output prfm_item_t pop_item
);

  prfm_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hdl/prfm_back.sv
module prfm_back
  import prfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop,
  input  prfm_item_t  pop_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] masked_word
);

  logic [NUM_REGS-1:0] open_win;
  logic [NUM_REGS-1:0] open_win_next;
  logic [SKIP_W-1:0]   skip [NUM_REGS];
  logic [SKIP_W-1:0]   skip_next [NUM_REGS];
  logic                use_hit;

  assign pop     = pop_valid && (!out_valid || !out_stall);
  assign use_hit = open_win[pop_item.reg_a] && pop_item.use_acc;

  always_comb begin
    logic [SKIP_W-1:0] sk;
    logic              close;
    logic [REG_W-1:0]  r_id;
    for (int r = 0; r < NUM_REGS; r++) begin
      r_id = REG_W'(r);
      sk = (pop_item.disp > skip[r]) ? pop_item.disp : skip[r];
      close = (pop_item.lis && pop_item.reg_d == r_id) ||
              (pop_item.blr && sk == '0) ||
              (pop_item.use_acc && pop_item.reg_a == r_id &&
               (pop_item.update || pop_item.reg_d == r_id));
      open_win_next[r] = open_win[r] && !close;
      if (!open_win[r]) begin
        skip_next[r] = skip[r];
      end else if (!close && sk != '0) begin
        skip_next[r] = sk - SKIP_W'(INSTR_BYTES);
      end else begin
        skip_next[r] = sk;
      end
      if (pop_item.lis && pop_item.reg_d == r_id) begin
        open_win_next[r] = 1'b1;
        skip_next[r]     = '0;
      end
      if (pop_item.last) begin
        open_win_next[r] = 1'b0;
        skip_next[r]     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_win  <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        skip[r] <= '0;
      end
    end else if (pop) begin
      open_win  <= open_win_next;
      out_valid <= 1'b1;
      for (int r = 0; r < NUM_REGS; r++) begin
        skip[r] <= skip_next[r];
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      masked_word <= pop_item.word & (use_hit ? KEEP_HIGH : '1);
    end
  end

endmodule

FILE: hdl/ppc_relocation_field_masker.sv
// each beat passes the decode register, queue and output register; every register window
// updates in parallel in the back part; one beat per cycle while out_stall is low
// reset: synchronous active-high rst closes all windows, clears skip distances and empties
//   the decode register, queue and output register; no clearing pass is needed
module ppc_relocation_field_masker
  import prfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  input  logic        last_of_section,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] masked_word
);

  // front to queue
  logic       push_valid;
  logic       push_ready;
  prfm_item_t push_item;

  // queue to back
  logic       pop_valid;
  logic       pop;
  prfm_item_t pop_item;

  // front: decodes opcode, registers, branch distance and static masks
  // (branch LI, small-data displacement and base, lis immediate)
  prfm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .instr_word      (instr_word),
    .last_of_section (last_of_section),
    .push_ready      (push_ready),
    .push_valid      (push_valid),
    .push_item       (push_item)
  );

  // two-entry queue decouples decode from the window tracker
  prfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // back: per-register lis windows with forward skip counters, plus output register
  prfm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .masked_word (masked_word)
  );

endmodule
